// ===== hw/rtl/rvhz_pkg.sv =====
// ----------------------------------------------------------------------------
// rvhz_pkg
// Shared constants, types and decode helpers for the RV32 hazard NOP
// reorder block.
// ----------------------------------------------------------------------------
package rvhz_pkg;

  localparam int WAIT_DEPTH_DEF = 8;

  // RV32 major opcodes that touch the register file
  localparam logic [6:0] OPC_R     = 7'b0110011;
  localparam logic [6:0] OPC_ALUI  = 7'b0010011;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;
  localparam logic [6:0] OPC_STORE = 7'b0100011;

  localparam logic [31:0] NOP_WORD = 32'h00000013;
  localparam logic [4:0]  REG_ZERO = 5'b00000;

  // Wait chain commands
  localparam logic [1:0] Q_HOLD = 2'd0;
  localparam logic [1:0] Q_ENQ  = 2'd1;
  localparam logic [1:0] Q_POP  = 2'd2;
  localparam logic [1:0] Q_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] word;
  } qcmd_t;

  // Destination register written by a word, zero when none
  function automatic logic [4:0] dest_of(input logic [31:0] w);
    logic [4:0] rd;
    rd = REG_ZERO;
    if (w[6:0] inside {OPC_R, OPC_ALUI, OPC_LOAD}) begin
      rd = w[11:7];
    end
    return rd;
  endfunction

  // Slots a word needs given the last two destinations: 2, 1 or 0
  function automatic logic [1:0] hazard_of(input logic [31:0] w,
                                           input logic [4:0]  near_rd,
                                           input logic [4:0]  far_rd);
    logic [4:0] rs1;
    logic [4:0] rs2;
    logic [1:0] slots;
    rs1 = REG_ZERO;
    rs2 = REG_ZERO;
    slots = 2'd0;
    if (w[6:0] inside {OPC_R, OPC_ALUI, OPC_LOAD, OPC_STORE}) begin
      rs1 = w[19:15];
    end
    if (w[6:0] inside {OPC_R, OPC_STORE}) begin
      rs2 = w[24:20];
    end
    if (near_rd != REG_ZERO && (rs1 == near_rd || rs2 == near_rd)) begin
      slots = 2'd2;
    end else if (far_rd != REG_ZERO && (rs1 == far_rd || rs2 == far_rd)) begin
      slots = 2'd1;
    end
    return slots;
  endfunction

endpackage

// ===== hw/rtl/rv_hazard_nop_reorder.sv =====
// ----------------------------------------------------------------------------
// rv_hazard_nop_reorder
// A new instruction word (action 0) that reads the destination of one of the
// last two issued words is preceded by filler slots; each slot takes the
// oldest hazard-free word from the wait chain, or a NOP (0x00000013). A word
// still in conflict joins the wait chain, or is preceded by NOPs when the
// chain is full. An end action (1) drains the chain in order. out_last marks
// the final result of each input item. The block works on one item at a
// time. When a new word needs slots, it makes at most two scan passes over
// the wait chain, which rotates one entry past the head per cycle unless a
// clean head waits for room at the output; the next item is accepted only
// once the current one is finished.
// ----------------------------------------------------------------------------
module rv_hazard_nop_reorder import rvhz_pkg::*; #(
  parameter int  WAIT_DEPTH = WAIT_DEPTH_DEF,
  localparam int CW = $clog2(WAIT_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_instr_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word,
  output logic        out_is_filler_nop,
  output logic        out_from_wait_queue,
  output logic        out_last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_FINAL = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  typedef struct packed {
    logic [31:0] word;
    logic        nop;
    logic        queued;
  } res_t;

  logic [2:0]    state_r,    state_nxt;
  logic [4:0]    near_r,     near_nxt;
  logic [4:0]    far_r,      far_nxt;
  logic [31:0]   word_r,     word_nxt;
  logic [1:0]    slots_r,    slots_nxt;
  logic          took_r,     took_nxt;
  logic [CW-1:0] pass_r,     pass_nxt;
  logic          hold_v_r,   hold_v_nxt;
  res_t          hold_r,     hold_nxt;
  logic          out_v_r,    out_v_nxt;
  res_t          out_r,      out_nxt;
  logic          out_last_r, out_last_nxt;

  qcmd_t         qcmd;
  logic [31:0]   head;
  logic [CW-1:0] count;
  logic          full;
  logic [1:0]    hz_head;
  logic [1:0]    hz_word;
  logic [1:0]    hz_in;
  logic          in_accept;
  logic          out_free;
  logic          emit_ok;
  logic          emit;
  res_t          emit_res;
  logic          flush;

  rvhz_queue #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (qcmd),
    .head_word (head),
    .count     (count)
  );

  assign full      = (count == CW'(WAIT_DEPTH));
  assign hz_head   = hazard_of(head, near_r, far_r);
  assign hz_word   = hazard_of(word_r, near_r, far_r);
  assign hz_in     = hazard_of(in_instr_word, near_r, far_r);
  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_v_r || !out_stall;
  assign emit_ok   = !hold_v_r || out_free;

  // Sequencer: scan, place, drain, then release the held result as last
  always_comb begin
    state_nxt = state_r;
    word_nxt  = word_r;
    slots_nxt = slots_r;
    took_nxt  = took_r;
    pass_nxt  = pass_r;
    qcmd.op   = Q_HOLD;
    qcmd.word = word_r;
    emit      = 1'b0;
    emit_res  = '{word: NOP_WORD, nop: 1'b1, queued: 1'b0};
    flush     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          word_nxt  = in_instr_word;
          slots_nxt = hz_in;
          took_nxt  = 1'b0;
          pass_nxt  = count;
          if (in_action) begin
            state_nxt = ST_DRAIN;
          end else if (hz_in == 2'd0) begin
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (pass_r != '0) begin
          // Issue a clean head into a free slot, otherwise rotate it back
          if (slots_r != 2'd0 && hz_head == 2'd0) begin
            if (emit_ok) begin
              emit      = 1'b1;
              emit_res  = '{word: head, nop: 1'b0, queued: 1'b1};
              qcmd.op   = Q_POP;
              slots_nxt = slots_r - 2'd1;
              took_nxt  = 1'b1;
              pass_nxt  = pass_r - CW'(1);
            end
          end else begin
            qcmd.op  = Q_ROT;
            pass_nxt = pass_r - CW'(1);
          end
        end else if (slots_r == 2'd0) begin
          state_nxt = ST_FINAL;
        end else if (!took_r) begin
          // Nothing fit this pass: fill the slot with a NOP
          if (emit_ok) begin
            emit      = 1'b1;
            slots_nxt = slots_r - 2'd1;
            pass_nxt  = count;
            took_nxt  = 1'b0;
            if (slots_r == 2'd1) begin
              state_nxt = ST_FINAL;
            end
          end
        end else begin
          pass_nxt = count;
          took_nxt = 1'b0;
        end
      end
      ST_FINAL: begin
        if (hz_word == 2'd0) begin
          if (emit_ok) begin
            emit      = 1'b1;
            emit_res  = '{word: word_r, nop: 1'b0, queued: 1'b0};
            state_nxt = ST_FLUSH;
          end
        end else if (!full) begin
          qcmd.op   = Q_ENQ;
          state_nxt = ST_FLUSH;
        end else if (emit_ok) begin
          emit = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (count == '0) begin
          state_nxt = ST_FLUSH;
        end else if (emit_ok) begin
          emit = 1'b1;
          if (hz_head == 2'd0) begin
            emit_res = '{word: head, nop: 1'b0, queued: 1'b1};
            qcmd.op  = Q_POP;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          flush     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance destination history on every issued word
  always_comb begin
    near_nxt = near_r;
    far_nxt  = far_r;
    if (emit) begin
      far_nxt  = near_r;
      near_nxt = emit_res.nop ? REG_ZERO : dest_of(emit_res.word);
    end
  end

  // Hold one result back until it is known whether it is the last
  always_comb begin
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
    if ((emit && hold_v_r) || flush) begin
      out_v_nxt    = 1'b1;
      out_nxt      = hold_r;
      out_last_nxt = flush;
    end
    if (emit) begin
      hold_v_nxt = 1'b1;
      hold_nxt   = emit_res;
    end else if (flush) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      near_r   <= REG_ZERO;
      far_r    <= REG_ZERO;
      slots_r  <= 2'd0;
      took_r   <= 1'b0;
      pass_r   <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      near_r   <= near_nxt;
      far_r    <= far_nxt;
      slots_r  <= slots_nxt;
      took_r   <= took_nxt;
      pass_r   <= pass_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid           = out_v_r;
  assign out_word            = out_r.word;
  assign out_is_filler_nop   = out_r.nop;
  assign out_from_wait_queue = out_r.queued;
  assign out_last            = out_last_r;

endmodule

// ===== hw/rtl/rvhz_cell.sv =====
// ----------------------------------------------------------------------------
// rvhz_cell
// One slot of the wait chain: holds a word, loads from its upper neighbor
// on a shift, or takes an inserted word.
// ----------------------------------------------------------------------------
module rvhz_cell (
  input  logic        clk,
  input  logic        shift,
  input  logic        ins,
  input  logic [31:0] ins_word,
  input  logic [31:0] nbr_word,
  output logic [31:0] word
);

  logic [31:0] word_r;
  logic [31:0] word_nxt;

  // Insert wins over shift
  always_comb begin
    word_nxt = word_r;
    if (ins) begin
      word_nxt = ins_word;
    end else if (shift) begin
      word_nxt = nbr_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== hw/rtl/rvhz_queue.sv =====
// ----------------------------------------------------------------------------
// rvhz_queue
// Wait chain: a row of cells shifting toward the head at cell 0. Supports
// append at the tail, pop of the head and rotation of the head to the tail.
// ----------------------------------------------------------------------------
module rvhz_queue import rvhz_pkg::*; #(
  parameter int  WAIT_DEPTH = WAIT_DEPTH_DEF,
  localparam int CW = $clog2(WAIT_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  qcmd_t         cmd,
  output logic [31:0]   head_word,
  output logic [CW-1:0] count
);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [31:0]   cell_word [WAIT_DEPTH];
  logic          shift;
  logic [31:0]   ins_word;

  assign shift    = (cmd.op == Q_POP) || (cmd.op == Q_ROT);
  assign ins_word = (cmd.op == Q_ENQ) ? cmd.word : cell_word[0];

  // Build the row of cells
  for (genvar k = 0; k < WAIT_DEPTH; k++) begin : g_cell
    logic        ins;
    logic [31:0] nbr;
    assign ins = ((cmd.op == Q_ENQ) && (count_r == CW'(k))) ||
                 ((cmd.op == Q_ROT) && (count_r - CW'(1) == CW'(k)));
    if (k == WAIT_DEPTH - 1) begin : g_tail
      assign nbr = cell_word[k];
    end else begin : g_mid
      assign nbr = cell_word[k+1];
    end
    rvhz_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .ins      (ins),
      .ins_word (ins_word),
      .nbr_word (nbr),
      .word     (cell_word[k])
    );
  end

  // Track fill level
  always_comb begin
    count_nxt = count_r;
    case (cmd.op)
      Q_ENQ:   count_nxt = count_r + CW'(1);
      Q_POP:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_word = cell_word[0];
  assign count     = count_r;

endmodule

// ===== sim/rvhz_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rvhz_checker
// Watches both channels of the hazard NOP reorder block. Each accepted input
// item is run through a local model of the issue rules (last two destinations,
// waiting words, filler NOPs). The model's results are queued, and each
// accepted result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module rvhz_checker import rvhz_pkg::*; #(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_instr_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_word,
  input  logic        out_is_filler_nop,
  input  logic        out_from_wait_queue,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] word;
    logic        filler;
    logic        queued;
    logic        last;
  } issued_t;

  issued_t     issue_q[$];   // results still to arrive, oldest first
  issued_t     burst_q[$];   // results of the item being modeled
  logic [31:0] parked_q[$];  // words held back in the model
  logic [4:0]  near_rd = REG_ZERO;
  logic [4:0]  far_rd = REG_ZERO;
  int          errs = 0;
  int          waiting = 0;

  assign fail_count = errs;
  assign pending = waiting;

  // Destination written by a word, zero when it writes nothing
  function automatic logic [4:0] dest_reg(input logic [31:0] w);
    case (w[6:0])
      OPC_R, OPC_ALUI, OPC_LOAD: return w[11:7];
      default: return REG_ZERO;
    endcase
  endfunction

  // Slots a word needs against the current destination history
  function automatic int slots_needed(input logic [31:0] w);
    logic [4:0] src_a;
    logic [4:0] src_b;
    src_a = REG_ZERO;
    src_b = REG_ZERO;
    case (w[6:0])
      OPC_R, OPC_STORE: begin
        src_a = w[19:15];
        src_b = w[24:20];
      end
      OPC_ALUI, OPC_LOAD: src_a = w[19:15];
      default: ;
    endcase
    if (near_rd != REG_ZERO && (src_a == near_rd || src_b == near_rd)) return 2;
    if (far_rd != REG_ZERO && (src_a == far_rd || src_b == far_rd)) return 1;
    return 0;
  endfunction

  // Issue one word and shift the destination history
  task automatic issue_word(input logic [31:0] w, input logic filler,
                            input logic queued);
    issued_t r;
    r = '{w, filler, queued, 1'b0};
    burst_q = {burst_q, r};
    far_rd = near_rd;
    near_rd = filler ? REG_ZERO : dest_reg(w);
  endtask

  // Work out the results of one input item and queue them
  task automatic model_item(input logic drain, input logic [31:0] w);
    int      need;
    int      j;
    bit      took;
    issued_t r;
    burst_q.delete();
    if (drain) begin
      foreach (parked_q[i]) begin
        need = slots_needed(parked_q[i]);
        repeat (need) issue_word(NOP_WORD, 1'b1, 1'b0);
        issue_word(parked_q[i], 1'b0, 1'b1);
      end
      parked_q.delete();
    end else begin
      // fill each slot with the oldest ready waiting word, else a NOP
      need = slots_needed(w);
      while (need > 0) begin
        took = 1'b0;
        j = 0;
        while (j < parked_q.size()) begin
          if (slots_needed(parked_q[j]) == 0) begin
            issue_word(parked_q[j], 1'b0, 1'b1);
            parked_q.delete(j);
            took = 1'b1;
            need--;
          end else begin
            j++;
          end
          if (need == 0) break;
        end
        if (!took) begin
          issue_word(NOP_WORD, 1'b1, 1'b0);
          need--;
        end
      end
      if (slots_needed(w) == 0) begin
        issue_word(w, 1'b0, 1'b0);
      end else if (parked_q.size() < WAIT_DEPTH) begin
        parked_q = {parked_q, w};
      end else begin
        // full wait chain: pad with NOPs until the word is clear
        need = slots_needed(w);
        repeat (need) issue_word(NOP_WORD, 1'b1, 1'b0);
        issue_word(w, 1'b0, 1'b0);
      end
    end
    foreach (burst_q[i]) begin
      r = burst_q[i];
      r.last = (i == burst_q.size() - 1);
      issue_q = {issue_q, r};
    end
  endtask

  task automatic report(input string field, input logic [31:0] want,
                        input logic [31:0] got);
    errs++;
    $display("%0t: mismatch on %s: expected %h, actual %h", $time, field, want, got);
  endtask

  // Predict on accepted input items, compare on accepted results
  always @(posedge clk) begin
    issued_t want;
    if (!rst_n) begin
      near_rd = REG_ZERO;
      far_rd = REG_ZERO;
      parked_q.delete();
      issue_q.delete();
    end else begin
      if (in_valid && !in_stall) model_item(in_action, in_instr_word);
      if (out_valid && !out_stall) begin
        if (issue_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, actual word %h", $time,
                   out_word);
        end else begin
          want = issue_q.pop_front();
          if (out_word !== want.word) report("word", want.word, out_word);
          if (out_is_filler_nop !== want.filler)
            report("is_filler_nop", 32'(want.filler), 32'(out_is_filler_nop));
          if (out_from_wait_queue !== want.queued)
            report("from_wait_queue", 32'(want.queued), 32'(out_from_wait_queue));
          if (out_last !== want.last) report("last", 32'(want.last), 32'(out_last));
        end
      end
    end
    waiting = issue_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the hazard NOP reorder block with a directed run of hazard patterns
// and end actions, then random instruction words biased toward a few
// registers so that near and far hazards are common. Both channels idle at
// random, with one calm stretch and one long result hold-off. Checking is
// done by rvhz_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb import rvhz_pkg::*; ();

  localparam int RANDOM_ITEMS = 350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_START = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 64;
  localparam logic ACT_WORD = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;
  localparam logic [6:0] OPC_LUI = 7'b0110111;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = ACT_WORD;
  logic [31:0] in_instr_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_word;
  logic        out_is_filler_nop;
  logic        out_from_wait_queue;
  logic        out_last;
  int          fail_count;
  int          pending;
  int          sent = 0;
  int          cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic        calm;

  assign calm = (sent >= 200 && sent < 260);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rv_hazard_nop_reorder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_instr_word      (in_instr_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_word           (out_word),
    .out_is_filler_nop  (out_is_filler_nop),
    .out_from_wait_queue(out_from_wait_queue),
    .out_last           (out_last)
  );

  rvhz_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_instr_word      (in_instr_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_word           (out_word),
    .out_is_filler_nop  (out_is_filler_nop),
    .out_from_wait_queue(out_from_wait_queue),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // Stall results at random; hold off once for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent >= HOLD_START) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 6);
    end
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] encode(input logic [6:0] opc, input logic [4:0] rd,
                                         input logic [4:0] rs1, input logic [4:0] rs2);
    return {7'b0, rs2, rs1, 3'b0, rd, opc};
  endfunction

  // Register number, mostly from a small set so hazards are frequent
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 99) < 80) return 5'($urandom_range(0, 3));
    return 5'($urandom);
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [6:0]  opc;
    w = $urandom;
    if ($urandom_range(0, 99) < 10) return w;
    case ($urandom_range(0, 4))
      0: opc = OPC_R;
      1: opc = OPC_ALUI;
      2: opc = OPC_LOAD;
      3: opc = OPC_STORE;
      default: opc = 7'($urandom);
    endcase
    w[6:0] = opc;
    w[11:7] = pick_reg();
    w[19:15] = pick_reg();
    w[24:20] = pick_reg();
    return w;
  endfunction

  // Offer one item, with a random gap first, and hold it until accepted
  task automatic send_item(input logic act, input logic [31:0] w);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_instr_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, empty drain, near and far hazards per type
    send_item(ACT_WORD, NOP_WORD);
    send_item(ACT_WORD, 32'h0000_0000);
    send_item(ACT_WORD, 32'hFFFF_FFFF);
    send_item(ACT_DRAIN, 32'hFFFF_FFFF);
    send_item(ACT_WORD, encode(OPC_R, 5'd5, 5'd1, 5'd2));
    send_item(ACT_WORD, encode(OPC_R, 5'd8, 5'd5, 5'd0));
    send_item(ACT_WORD, encode(OPC_ALUI, 5'd6, 5'd3, 5'd0));
    send_item(ACT_WORD, encode(OPC_LUI, 5'd9, 5'd6, 5'd6));
    send_item(ACT_WORD, encode(OPC_LOAD, 5'd7, 5'd6, 5'd0));
    send_item(ACT_WORD, encode(OPC_STORE, 5'd0, 5'd1, 5'd7));
    send_item(ACT_WORD, encode(OPC_ALUI, 5'd10, 5'd7, 5'd0));
    send_item(ACT_WORD, encode(OPC_STORE, 5'd0, 5'd10, 5'd4));
    send_item(ACT_WORD, encode(OPC_ALUI, 5'd0, 5'd1, 5'd0));
    send_item(ACT_WORD, encode(OPC_R, 5'd2, 5'd0, 5'd0));
    send_item(ACT_WORD, encode(OPC_ALUI, 5'd31, 5'd31, 5'd0));
    send_item(ACT_WORD, encode(OPC_R, 5'd31, 5'd31, 5'd31));
    send_item(ACT_WORD, encode(OPC_STORE, 5'd31, 5'd31, 5'd31));
    send_item(ACT_DRAIN, 32'h0000_0000);
    send_item(ACT_WORD, 32'hFFFF_FFB3);

    // random: mostly hazard-prone words, some end actions and noise
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 8) send_item(ACT_DRAIN, $urandom);
      else send_item(ACT_WORD, random_word());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // wait out outstanding results, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
